// ===== rtl/spb_pkg.sv =====
package spb_pkg;

    localparam int MZ_W   = 24;
    localparam int RES_W  = 20;
    localparam int INT_W  = 32;
    localparam int ADDR_W = 12;
    localparam int SUM_W  = 48;
    localparam int VAL_W  = 16;
    localparam int CNT_W  = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 24;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_MIN_MZ     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_MZ     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION = 2'd2;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DROPPED = 2'd1,
        ST_ZERO    = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_ADD_RD,
        S_ADD_WR,
        S_RD_RD,
        S_RD_DIV,
        S_RD_SQRT,
        S_OUT
    } t_state;

endpackage

// ===== rtl/spectrum_peak_binning.sv =====
// add: bin division, memory read, write back, then the result (a bin beyond BIN_COUNT is dropped unwritten)
// add of a peak below min_mz: result in the cycle after accept
// read: memory read, fraction division, square root, a bit a cycle (zero total or bad address skips to result)
// clear: all BIN_COUNT rows, one memory row a cycle, then the result
// one word in flight; the next word is accepted the cycle after the result is taken
// sync active low reset restores registers and runs the same clearing pass, no word accepted
module spectrum_peak_binning #(
    parameter int BIN_COUNT = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [spb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [spb_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_cmd,
    input  logic [spb_pkg::MZ_W-1:0]      i_mz,
    input  logic [spb_pkg::INT_W-1:0]     i_intensity,
    input  logic [spb_pkg::ADDR_W-1:0]    i_bin_address,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [spb_pkg::VAL_W-1:0]     o_bin_value,
    output logic                          o_bin_occupied,
    output logic [spb_pkg::CNT_W-1:0]     o_occupied_count,
    output logic [1:0]                    o_status
);

    localparam int BW = $clog2(BIN_COUNT);
    localparam int CW = BW + 1;
    localparam int QW = spb_pkg::MZ_W;
    localparam int DW = $clog2(QW + 1);

    // each row holds sum and occupancy bit
    logic [spb_pkg::SUM_W:0] mem [BIN_COUNT];
    logic [spb_pkg::SUM_W:0] r_rdata;
    logic                    mem_we;
    logic [BW-1:0]           mem_waddr;
    logic [spb_pkg::SUM_W:0] mem_wdata;
    logic [BW-1:0]           mem_raddr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    spb_pkg::t_state r_state, n_state;
    logic [spb_pkg::MZ_W-1:0]  r_min_mz, r_max_mz;
    logic [spb_pkg::RES_W-1:0] r_res;
    logic [spb_pkg::SUM_W-1:0] r_total;
    logic [CW-1:0]             r_occ_cnt;
    logic [BW-1:0]             r_clr;
    logic                      r_clr_rsp;
    logic [spb_pkg::MZ_W-1:0]  r_mz;
    logic [spb_pkg::INT_W-1:0] r_int;
    logic [spb_pkg::ADDR_W-1:0] r_addr;
    logic [QW-1:0]             r_dq;
    logic [spb_pkg::RES_W-1:0] r_drem;
    logic [DW-1:0]             r_step;
    logic [BW-1:0]             r_bin;
    logic [spb_pkg::SUM_W:0]   r_frem;
    logic [31:0]               r_fq;
    logic [33:0]               r_sx;
    logic [16:0]               r_sr;
    logic [spb_pkg::VAL_W-1:0] r_val;
    logic                      r_occ;
    logic [1:0]                r_stat;

    logic in_fire;
    assign in_fire = i_valid && o_ready;

    logic [spb_pkg::RES_W-1:0] res_eff;
    assign res_eff = (r_res == '0) ? spb_pkg::RES_W'(1) : r_res;

    // restoring division step for bin
    logic [spb_pkg::RES_W:0] dtry;
    assign dtry = {r_drem, r_dq[QW-1]} - {1'b0, res_eff};

    // fraction division step
    logic [spb_pkg::SUM_W+1:0] fsh;
    logic [spb_pkg::SUM_W+1:0] ftry;
    assign fsh  = {r_frem, 1'b0};
    assign ftry = fsh - {2'b0, r_total};

    // square root step: two bits a cycle from r_fq
    logic [33:0] sx_n;
    logic [18:0] strial;
    logic [18:0] stry;
    assign sx_n   = {r_sx[31:0], r_fq[31:30]};
    assign strial = {r_sr, 2'b01};
    assign stry   = sx_n[18:0] - strial;

    logic [spb_pkg::SUM_W:0] add_sum;
    logic [spb_pkg::SUM_W-1:0] sat_sum;
    assign add_sum = {1'b0, r_rdata[spb_pkg::SUM_W-1:0]} + (spb_pkg::SUM_W+1)'(r_int);
    assign sat_sum = add_sum[spb_pkg::SUM_W] ? spb_pkg::SUM_MAX
                                             : add_sum[spb_pkg::SUM_W-1:0];
    logic [spb_pkg::SUM_W:0] tot_sum;
    assign tot_sum = {1'b0, r_total} + (spb_pkg::SUM_W+1)'(i_intensity);

    logic bin_big;
    assign bin_big = 32'(r_dq) >= 32'(BIN_COUNT);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            spb_pkg::S_CLEAR: begin
                if (r_clr == BW'(BIN_COUNT - 1))
                    n_state = r_clr_rsp ? spb_pkg::S_OUT : spb_pkg::S_IDLE;
            end
            spb_pkg::S_IDLE: begin
                if (in_fire) begin
                    unique case (i_cmd)
                        spb_pkg::CMD_ADD:   n_state = (i_mz < r_min_mz) ? spb_pkg::S_OUT
                                                                        : spb_pkg::S_DIV;
                        spb_pkg::CMD_READ:  n_state = spb_pkg::S_RD_RD;
                        spb_pkg::CMD_CLEAR: n_state = spb_pkg::S_CLEAR;
                        default:            n_state = spb_pkg::S_OUT;
                    endcase
                end
            end
            spb_pkg::S_DIV:
                if (r_step == DW'(QW - 1)) n_state = spb_pkg::S_ADD_RD;
            spb_pkg::S_ADD_RD:  n_state = bin_big ? spb_pkg::S_OUT : spb_pkg::S_ADD_WR;
            spb_pkg::S_ADD_WR:  n_state = spb_pkg::S_OUT;
            spb_pkg::S_RD_RD: begin
                if (r_total == '0 || 32'(r_addr) >= 32'(BIN_COUNT))
                    n_state = spb_pkg::S_OUT;
                else
                    n_state = spb_pkg::S_RD_DIV;
            end
            spb_pkg::S_RD_DIV:
                if (r_step == DW'(0)) n_state = spb_pkg::S_RD_SQRT;
            spb_pkg::S_RD_SQRT:
                if (r_step == DW'(15)) n_state = spb_pkg::S_OUT;
            spb_pkg::S_OUT:     if (i_ready) n_state = spb_pkg::S_IDLE;
            default:            n_state = spb_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ready   = (r_state == spb_pkg::S_IDLE);
        o_valid   = (r_state == spb_pkg::S_OUT);
        mem_we    = 1'b0;
        mem_waddr = r_bin;
        mem_wdata = {r_rdata[spb_pkg::SUM_W] || (r_mz <= r_max_mz), sat_sum};
        mem_raddr = r_bin;
        if (r_state == spb_pkg::S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr;
            mem_wdata = '0;
        end else if (r_state == spb_pkg::S_ADD_WR) begin
            mem_we = 1'b1;
        end
        if (r_state == spb_pkg::S_IDLE) mem_raddr = BW'(i_bin_address);
        if (r_state == spb_pkg::S_ADD_RD) mem_raddr = r_dq[BW-1:0];
    end

    assign o_bin_value      = r_val;
    assign o_bin_occupied   = r_occ;
    assign o_occupied_count = spb_pkg::CNT_W'(r_occ_cnt);
    assign o_status         = r_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= spb_pkg::S_CLEAR;
            r_min_mz  <= '0;
            r_max_mz  <= spb_pkg::MZ_W'(2048000);
            r_res     <= spb_pkg::RES_W'(1024);
            r_total   <= '0;
            r_occ_cnt <= '0;
            r_clr     <= '0;
            r_clr_rsp <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    spb_pkg::REG_MIN_MZ:     r_min_mz <= i_cfg_data;
                    spb_pkg::REG_MAX_MZ:     r_max_mz <= i_cfg_data;
                    spb_pkg::REG_RESOLUTION: r_res <= i_cfg_data[spb_pkg::RES_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == spb_pkg::S_CLEAR) r_clr <= r_clr + 1'b1;
            if (in_fire) r_clr_rsp <= (i_cmd == spb_pkg::CMD_CLEAR);
            if (in_fire && i_cmd == spb_pkg::CMD_CLEAR) begin
                r_total   <= '0;
                r_occ_cnt <= '0;
                r_clr     <= '0;
            end
            if (in_fire && i_cmd == spb_pkg::CMD_ADD)
                r_total <= tot_sum[spb_pkg::SUM_W] ? spb_pkg::SUM_MAX
                                                    : tot_sum[spb_pkg::SUM_W-1:0];
            if (r_state == spb_pkg::S_ADD_WR && !r_rdata[spb_pkg::SUM_W] && r_mz <= r_max_mz)
                r_occ_cnt <= r_occ_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            spb_pkg::S_IDLE: begin
                r_mz   <= i_mz;
                r_int  <= i_intensity;
                r_addr <= i_bin_address;
                r_dq   <= i_mz - r_min_mz;
                r_drem <= '0;
                r_step <= '0;
                r_bin  <= BW'(i_bin_address);
                r_val  <= '0;
                r_occ  <= 1'b0;
                r_stat <= (i_cmd == spb_pkg::CMD_ADD && i_mz < r_min_mz)
                          ? spb_pkg::ST_DROPPED : spb_pkg::ST_OK;
            end
            spb_pkg::S_DIV: begin
                r_step <= r_step + 1'b1;
                if (!dtry[spb_pkg::RES_W]) begin
                    r_drem <= dtry[spb_pkg::RES_W-1:0];
                    r_dq   <= {r_dq[QW-2:0], 1'b1};
                end else begin
                    r_drem <= {r_drem[spb_pkg::RES_W-2:0], r_dq[QW-1]};
                    r_dq   <= {r_dq[QW-2:0], 1'b0};
                end
            end
            spb_pkg::S_ADD_RD: begin
                r_bin <= r_dq[BW-1:0];
                if (bin_big) r_stat <= spb_pkg::ST_DROPPED;
            end
            spb_pkg::S_RD_RD: begin
                r_frem <= {1'b0, r_rdata[spb_pkg::SUM_W-1:0]};
                r_fq   <= '0;
                r_sx   <= '0;
                r_sr   <= '0;
                r_step <= DW'(31);
                if (32'(r_addr) < 32'(BIN_COUNT)) r_occ <= r_rdata[spb_pkg::SUM_W];
                if (r_total == '0) r_stat <= spb_pkg::ST_ZERO;
                if (32'(r_addr) < 32'(BIN_COUNT) && r_total != '0
                    && r_rdata[spb_pkg::SUM_W-1:0] >= r_total) begin
                    r_val <= '1;
                end
            end
            spb_pkg::S_RD_DIV: begin
                r_step <= (r_step == DW'(0)) ? DW'(0) : r_step - 1'b1;
                if (!ftry[spb_pkg::SUM_W+1]) begin
                    r_frem <= ftry[spb_pkg::SUM_W:0];
                    r_fq   <= {r_fq[30:0], 1'b1};
                end else begin
                    r_frem <= fsh[spb_pkg::SUM_W:0];
                    r_fq   <= {r_fq[30:0], 1'b0};
                end
            end
            spb_pkg::S_RD_SQRT: begin
                r_step <= r_step + 1'b1;
                r_fq   <= {r_fq[29:0], 2'b00};
                if (!stry[18]) begin
                    r_sx <= {sx_n[33:19], stry};
                    r_sr <= {r_sr[15:0], 1'b1};
                end else begin
                    r_sx <= sx_n;
                    r_sr <= {r_sr[15:0], 1'b0};
                end
                if (r_step == DW'(15) && r_val != '1)
                    r_val <= stry[18] ? {r_sr[14:0], 1'b0} : {r_sr[14:0], 1'b1};
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/spb_checker.sv =====
module spb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_bin_value,
    input logic        o_bin_occupied,
    input logic [1:0]  o_status
);

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready)) else $error("ready while word pending");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_bin_value))
        else $error("result dropped");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= spb_pkg::ST_ZERO) else $error("bad status");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == spb_pkg::ST_ZERO |-> o_bin_value == '0)
        else $error("value on zero total");

    a_drop_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == spb_pkg::ST_DROPPED |-> !o_bin_occupied)
        else $error("occupied on dropped peak");

endmodule

bind spectrum_peak_binning spb_checker u_spb_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_bin_value(o_bin_value),
    .o_bin_occupied(o_bin_occupied), .o_status(o_status)
);
